[src/afe_pkg.sv]
package afe_pkg;

    localparam int CFG_W = 13;
    localparam int MAX_BUFFER_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [CFG_W-1:0] BUF_SIZE_RESET = 13'd4096;

    typedef enum logic [1:0] {
        REG_FADE_MODE   = 2'd0,
        REG_BUFFER_SIZE = 2'd1,
        REG_FADE_OFFSET = 2'd2,
        REG_RAMP_LEN    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        K_PASS  = 2'd0,
        K_ZERO  = 2'd1,
        K_SCALE = 2'd2
    } kind_t;

    typedef struct packed {
        logic             fade_mode;
        logic [CFG_W-1:0] buffer_size;
        logic [CFG_W-1:0] fade_offset;
        logic [CFG_W-1:0] ramp_len;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic [CFG_W-1:0] mult;
        logic [CFG_W-1:0] total;
        logic             block_end;
    } ctrl_t;

endpackage

[src/afe_front.sv]
module afe_front #(
    parameter int MAX_BUFFER_SAMPLES = afe_pkg::MAX_BUFFER_SAMPLES_DEF,
    parameter int SAMPLE_BITS = afe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  afe_pkg::cfg_t                 cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          q_full,
    output logic                          push,
    output logic signed [SAMPLE_BITS-1:0] push_sample,
    output afe_pkg::ctrl_t                push_ctrl
);

    localparam int CW = afe_pkg::CFG_W;
    localparam int IDX_W = $clog2(MAX_BUFFER_SAMPLES);
    localparam logic [CW-1:0] N_MAX = CW'(MAX_BUFFER_SAMPLES);

    logic [IDX_W-1:0] index_reg, index_next;
    logic [IDX_W-1:0] idx;
    logic [CW-1:0]    n, off, total, i13;
    logic [CW:0]      sum;
    logic             last;

    assign s_ready = !q_full;
    assign push = s_valid && s_ready;
    assign push_sample = s_sample_in;

    always_comb begin
        if (cfg.buffer_size == '0) begin
            n = CW'(1);
        end else if (32'(cfg.buffer_size) > 32'(MAX_BUFFER_SAMPLES)) begin
            n = N_MAX;
        end else begin
            n = cfg.buffer_size;
        end

        idx = (32'(index_reg) >= 32'(n)) ? '0 : index_reg;
        i13 = CW'(idx);

        off = (cfg.fade_offset < n) ? cfg.fade_offset : n;
        sum = {1'b0, off} + {1'b0, cfg.ramp_len};
        if (sum > {1'b0, n}) begin
            off = '0;
            total = n;
        end else begin
            total = sum[CW-1:0];
        end

        push_ctrl.total = total;
        if (!cfg.fade_mode) begin
            push_ctrl.mult = i13;
            if (i13 < off) begin
                push_ctrl.kind = afe_pkg::K_ZERO;
            end else if (i13 < total) begin
                push_ctrl.kind = afe_pkg::K_SCALE;
            end else begin
                push_ctrl.kind = afe_pkg::K_PASS;
            end
        end else begin
            push_ctrl.mult = total - i13;
            if (i13 >= total) begin
                push_ctrl.kind = afe_pkg::K_ZERO;
            end else if (i13 >= off) begin
                push_ctrl.kind = afe_pkg::K_SCALE;
            end else begin
                push_ctrl.kind = afe_pkg::K_PASS;
            end
        end

        last = ((i13 + CW'(1)) == n);
        push_ctrl.block_end = last;
        index_next = last ? '0 : idx + IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
        end else if (push) begin
            index_reg <= index_next;
        end
    end

endmodule

[src/afe_queue.sv]
module afe_queue #(
    parameter int SAMPLE_BITS = afe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] push_sample,
    input  afe_pkg::ctrl_t                push_ctrl,
    output logic                          full,
    input  logic                          pop,
    output logic                          q_valid,
    output logic signed [SAMPLE_BITS-1:0] q_sample,
    output afe_pkg::ctrl_t                q_ctrl
);

    logic signed [SAMPLE_BITS-1:0]   smp_reg  [afe_pkg::QDEPTH];
    afe_pkg::ctrl_t                  ctrl_reg [afe_pkg::QDEPTH];
    logic [afe_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [afe_pkg::QCNT_W-1:0]      count_reg;

    assign full = (32'(count_reg) == afe_pkg::QDEPTH);
    assign q_valid = (count_reg != '0);
    assign q_sample = smp_reg[rd_ptr_reg];
    assign q_ctrl = ctrl_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            smp_reg[wr_ptr_reg] <= push_sample;
            ctrl_reg[wr_ptr_reg] <= push_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/afe_back.sv]
module afe_back #(
    parameter int SAMPLE_BITS = afe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  logic signed [SAMPLE_BITS-1:0] q_sample,
    input  afe_pkg::ctrl_t                q_ctrl,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_block_end
);

    localparam int CW = afe_pkg::CFG_W;
    localparam int PW = SAMPLE_BITS + CW;
    localparam int CNT_W = $clog2(PW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                  state_reg, state_next;
    logic                    neg_reg, neg_next;
    logic [SAMPLE_BITS-1:0]  mag_reg, mag_next;
    logic [CW-1:0]           mult_reg, mult_next;
    logic [CW-1:0]           total_reg, total_next;
    logic                    be_reg, be_next;
    logic [PW-1:0]           quo_reg, quo_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]  res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0]  m_sample_reg, m_sample_next;
    logic                    m_be_reg, m_be_next;
    logic [CW:0]             shifted;
    logic [CW:0]             diff;
    logic [SAMPLE_BITS-1:0]  quo_low;
    logic                    out_free;

    assign m_valid = m_valid_reg;
    assign m_sample_out = $signed(m_sample_reg);
    assign m_block_end = m_be_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        mult_next = mult_reg;
        total_next = total_reg;
        be_next = be_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        m_valid_next = m_valid_reg;
        m_sample_next = m_sample_reg;
        m_be_next = m_be_reg;
        pop = 1'b0;

        shifted = {rem_reg, quo_reg[PW-1]};
        diff = shifted - {1'b0, total_reg};
        quo_low = quo_reg[SAMPLE_BITS-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop = 1'b1;
                    be_next = q_ctrl.block_end;
                    neg_next = q_sample[SAMPLE_BITS-1];
                    mag_next = q_sample[SAMPLE_BITS-1] ? (~q_sample + 1'b1) : q_sample;
                    mult_next = q_ctrl.mult;
                    total_next = q_ctrl.total;
                    case (q_ctrl.kind)
                        afe_pkg::K_ZERO: begin
                            res_next = '0;
                            state_next = ST_FIN;
                        end
                        afe_pkg::K_SCALE: begin
                            state_next = ST_MUL;
                        end
                        afe_pkg::K_PASS: begin
                            res_next = q_sample;
                            state_next = ST_FIN;
                        end
                        default: begin
                            res_next = q_sample;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                quo_next = PW'(mag_reg) * PW'(mult_reg);
                rem_next = '0;
                cnt_next = CNT_W'(PW);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    res_next = neg_reg ? (~quo_low + 1'b1) : quo_low;
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                    if (shifted >= {1'b0, total_reg}) begin
                        rem_next = diff[CW-1:0];
                        quo_next = {quo_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_next = shifted[CW-1:0];
                        quo_next = {quo_reg[PW-2:0], 1'b0};
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sample_next = res_reg;
                    m_be_next = be_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        mult_reg <= mult_next;
        total_reg <= total_next;
        be_reg <= be_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
        m_sample_reg <= m_sample_next;
        m_be_reg <= m_be_next;
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (total_reg != '0))
        else $error("divide with zero total");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_DIV) && (32'(cnt_reg) == PW))
        else $error("divider not started with full count");

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && m_valid_reg && !m_ready) |=>
            (state_reg == ST_FIN) && m_valid_reg)
        else $error("result lost while output stalled");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_valid) |=> (state_reg != ST_IDLE))
        else $error("queued item not taken");
`endif

endmodule

[src/audio_fade_envelope_unit.sv]
// channel   | handshake        | payload
// ----------+------------------+------------------------------------------
// input     | s_valid/s_ready  | s_sample_in
// result    | m_valid/m_ready  | m_sample_out, m_block_end
// config    | apb psel/penable | paddr, pwdata, prdata (pready tied high)
//
// zeroed or passed samples skip the multiply and divide steps in the back end, scaled
// samples pass through the multiply step and the one-bit-a-cycle divider
// a two-item queue lets the front accept while the divider works
// the output register holds a result while the next item is computed
// aresetn is synchronous, active low; clears the index, queue and valid flags and resets the config registers

module audio_fade_envelope_unit #(
    parameter int MAX_BUFFER_SAMPLES = afe_pkg::MAX_BUFFER_SAMPLES_DEF,
    parameter int SAMPLE_BITS = afe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afe_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [afe_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [afe_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_sample_out,
    output logic                                m_block_end
);

    localparam int CW = afe_pkg::CFG_W;
    localparam int DW = afe_pkg::APB_DATA_W;

    logic                          fade_mode_reg;
    logic [CW-1:0]                 buffer_size_reg;
    logic [CW-1:0]                 fade_offset_reg;
    logic [CW-1:0]                 ramp_len_reg;
    afe_pkg::cfg_t                 cfg;
    afe_pkg::reg_idx_t             reg_idx;
    logic                          wr_en;
    logic                          q_full, push, pop, q_valid;
    logic signed [SAMPLE_BITS-1:0] push_sample, q_sample;
    afe_pkg::ctrl_t                push_ctrl, q_ctrl;

    assign pready = 1'b1;
    assign reg_idx = afe_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite && pready;

    assign cfg.fade_mode = fade_mode_reg;
    assign cfg.buffer_size = buffer_size_reg;
    assign cfg.fade_offset = fade_offset_reg;
    assign cfg.ramp_len = ramp_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_mode_reg <= 1'b0;
            buffer_size_reg <= afe_pkg::BUF_SIZE_RESET;
            fade_offset_reg <= '0;
            ramp_len_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                afe_pkg::REG_FADE_MODE:   fade_mode_reg <= pwdata[0];
                afe_pkg::REG_BUFFER_SIZE: buffer_size_reg <= pwdata[CW-1:0];
                afe_pkg::REG_FADE_OFFSET: fade_offset_reg <= pwdata[CW-1:0];
                afe_pkg::REG_RAMP_LEN:    ramp_len_reg <= pwdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            afe_pkg::REG_FADE_MODE:   prdata = DW'(fade_mode_reg);
            afe_pkg::REG_BUFFER_SIZE: prdata = DW'(buffer_size_reg);
            afe_pkg::REG_FADE_OFFSET: prdata = DW'(fade_offset_reg);
            afe_pkg::REG_RAMP_LEN:    prdata = DW'(ramp_len_reg);
            default:                  prdata = '0;
        endcase
    end

    afe_front #(
        .MAX_BUFFER_SAMPLES(MAX_BUFFER_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample_in(s_sample_in),
        .q_full(q_full),
        .push(push),
        .push_sample(push_sample),
        .push_ctrl(push_ctrl)
    );

    afe_queue #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(push),
        .push_sample(push_sample),
        .push_ctrl(push_ctrl),
        .full(q_full),
        .pop(pop),
        .q_valid(q_valid),
        .q_sample(q_sample),
        .q_ctrl(q_ctrl)
    );

    afe_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_valid(q_valid),
        .q_sample(q_sample),
        .q_ctrl(q_ctrl),
        .pop(pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_sample_out(m_sample_out),
        .m_block_end(m_block_end)
    );

endmodule

[bench/testbench.sv]
module testbench;

    localparam int SW = afe_pkg::SAMPLE_BITS_DEF;
    localparam int MAXN = afe_pkg::MAX_BUFFER_SAMPLES_DEF;
    localparam int CFG_W = afe_pkg::CFG_W;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 60;
    localparam logic FADE_IN = 1'b0;
    localparam logic FADE_OUT = 1'b1;

    typedef struct packed {
        logic signed [SW-1:0] smp;
        logic                 at_end;
    } faded_t;

    typedef struct packed {
        bit                   is_cfg;
        afe_pkg::reg_idx_t    rsel;
        logic [31:0]          wval;
        logic signed [SW-1:0] smp;
        bit                   typed;
        logic signed [SW-1:0] want;
        bit                   want_end;
    } drow_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [afe_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [afe_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [afe_pkg::APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SW-1:0] s_sample_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SW-1:0] m_sample_out;
    logic m_block_end;

    // shadow of the block's registers and sample position
    afe_pkg::cfg_t fade_cfg = '{fade_mode: FADE_IN, buffer_size: afe_pkg::BUF_SIZE_RESET,
                                fade_offset: '0, ramp_len: '0};
    int blk_pos = 0;

    faded_t faded_q[$];
    faded_t head;
    drow_t dir_q[$];

    int errors = 0;
    int sent = 0;
    int checked = 0;
    int ends_seen = 0;
    int cfg_writes = 0;
    int cycles = 0;
    int hold_cnt = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    bit calm = 1'b0;

    audio_fade_envelope_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_block_end  (m_block_end)
    );

    always #5 aclk = ~aclk;

    function automatic faded_t fade_sample(input logic signed [SW-1:0] x);
        int n;
        int i;
        int off;
        int len;
        int total;
        longint y;
        faded_t r;
        n = (fade_cfg.buffer_size == 0) ? 1 :
            ((fade_cfg.buffer_size > MAXN) ? MAXN : int'(fade_cfg.buffer_size));
        if (blk_pos >= n)
            blk_pos = 0;
        i = blk_pos;
        off = (fade_cfg.fade_offset < n) ? int'(fade_cfg.fade_offset) : n;
        len = int'(fade_cfg.ramp_len);
        if (off + len > n) begin
            off = 0;
            len = n;
        end
        total = off + len;
        if (fade_cfg.fade_mode == FADE_IN) begin
            if (i < off)
                y = 0;
            else if (i < total)
                y = (longint'(x) * i) / total;
            else
                y = longint'(x);
        end else begin
            if (i >= total)
                y = 0;
            else if (i >= off)
                y = (longint'(x) * (total - i)) / total;
            else
                y = longint'(x);
        end
        r.smp = y[SW-1:0];
        r.at_end = (i == n - 1);
        blk_pos = (i + 1 >= n) ? 0 : i + 1;
        return r;
    endfunction

    function automatic drow_t cfg_row(input afe_pkg::reg_idx_t r, input logic [31:0] v);
        drow_t d;
        d = '0;
        d.is_cfg = 1'b1;
        d.rsel = r;
        d.wval = v;
        return d;
    endfunction

    function automatic drow_t calc_row(input logic signed [SW-1:0] s);
        drow_t d;
        d = '0;
        d.smp = s;
        return d;
    endfunction

    function automatic drow_t known_row(input logic signed [SW-1:0] s,
                                        input logic signed [SW-1:0] w, input bit e);
        drow_t d;
        d = '0;
        d.smp = s;
        d.typed = 1'b1;
        d.want = w;
        d.want_end = e;
        return d;
    endfunction

    task automatic reg_write(input afe_pkg::reg_idx_t r, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (r)
            afe_pkg::REG_FADE_MODE:   fade_cfg.fade_mode = v[0];
            afe_pkg::REG_BUFFER_SIZE: fade_cfg.buffer_size = v[CFG_W-1:0];
            afe_pkg::REG_FADE_OFFSET: fade_cfg.fade_offset = v[CFG_W-1:0];
            afe_pkg::REG_RAMP_LEN:    fade_cfg.ramp_len = v[CFG_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic offer_sample(input logic signed [SW-1:0] v);
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_in <= v;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // sender stops and waits for every outstanding result
    task automatic settle();
        s_valid <= 1'b0;
        while (faded_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (faded_q.size() == 0) begin
                $error("unexpected result item: sample_out %0d block_end %0b",
                       $signed(m_sample_out), m_block_end);
                errors++;
            end else begin
                head = faded_q.pop_front();
                checked++;
                if (head.at_end)
                    ends_seen++;
                if (m_sample_out !== head.smp) begin
                    $error("sample_out: expected %0d, actual %0d",
                           $signed(head.smp), $signed(m_sample_out));
                    errors++;
                end
                if (m_block_end !== head.at_end) begin
                    $error("block_end: expected %0b, actual %0b", head.at_end, m_block_end);
                    errors++;
                end
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("audio_fade_envelope_unit: mismatch");
            $finish;
        end
    end

    initial begin
        int ph;
        int nsmp;
        int base_sent;
        int base_n;
        int sz;
        int off_v;
        int len_v;
        logic md;
        logic signed [SW-1:0] smp;
        faded_t r;

        dir_q = '{
            // after reset: fade in with an empty ramp passes everything
            known_row(16'sh7FFF, 16'sh7FFF, 1'b0),
            known_row(16'sh8000, 16'sh8000, 1'b0),
            known_row(16'sh0000, 16'sh0000, 1'b0),
            known_row(-16'sd1, -16'sd1, 1'b0),
            // shrunken block restarts the index
            cfg_row(afe_pkg::REG_BUFFER_SIZE, 32'd1),
            known_row(16'sd1234, 16'sd1234, 1'b1),
            // zero size acts as one sample
            cfg_row(afe_pkg::REG_BUFFER_SIZE, 32'd0),
            known_row(-16'sd5, -16'sd5, 1'b1),
            // oversize saturates, upper bits dropped
            cfg_row(afe_pkg::REG_BUFFER_SIZE, 32'hFFFF_FFFF),
            known_row(16'sd7, 16'sd7, 1'b0),
            // fade out with an empty ramp zeroes everything
            cfg_row(afe_pkg::REG_FADE_MODE, 32'hFFFF_FFFF),
            known_row(16'sh7FFF, 16'sh0000, 1'b0),
            known_row(16'sh8000, 16'sh0000, 1'b0),
            cfg_row(afe_pkg::REG_BUFFER_SIZE, 32'd4),
            cfg_row(afe_pkg::REG_FADE_OFFSET, 32'd1),
            cfg_row(afe_pkg::REG_RAMP_LEN, 32'd2),
            known_row(16'sd5, 16'sh0000, 1'b1),
            known_row(16'sd1000, 16'sd1000, 1'b0),
            calc_row(16'sh8000),
            calc_row(16'sh7FFF),
            cfg_row(afe_pkg::REG_FADE_MODE, 32'hFFFF_FFFE),
            known_row(-16'sd7, -16'sd7, 1'b1),
            known_row(16'sh7FFF, 16'sh0000, 1'b0),
            calc_row(16'sh8000),
            calc_row(16'sh7FFF),
            // ramp past the block end falls back to the whole block
            cfg_row(afe_pkg::REG_FADE_OFFSET, 32'h0000_1FFF),
            calc_row(16'sh7FFF),
            known_row(16'sh8000, 16'sh0000, 1'b0),
            cfg_row(afe_pkg::REG_RAMP_LEN, 32'd0),
            cfg_row(afe_pkg::REG_FADE_OFFSET, 32'd4),
            known_row(16'sh7FFF, 16'sh0000, 1'b0)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_q[k]) begin
            if (dir_q[k].is_cfg) begin
                settle();
                reg_write(dir_q[k].rsel, dir_q[k].wval);
            end else begin
                offer_sample(dir_q[k].smp);
                r = fade_sample(dir_q[k].smp);
                if (dir_q[k].typed) begin
                    r.smp = dir_q[k].want;
                    r.at_end = dir_q[k].want_end;
                end
                faded_q.push_back(r);
            end
        end

        base_sent = sent;
        ph = 0;
        while (sent < base_sent + RANDOM_ITEMS) begin
            settle();
            calm = 1'b0;
            md = ($urandom_range(0, 1) == 1) ? FADE_OUT : FADE_IN;
            case ($urandom_range(0, 9))
                0: sz = 0;
                1: sz = MAXN;
                2: sz = 8191;
                3: sz = $urandom_range(MAXN + 1, 8191);
                4: sz = $urandom_range(1, MAXN);
                default: sz = $urandom_range(1, 40);
            endcase
            base_n = (sz == 0) ? 1 : ((sz > MAXN) ? MAXN : sz);
            case ($urandom_range(0, 7))
                0: off_v = 0;
                1: off_v = base_n;
                2: off_v = 8191;
                3: off_v = $urandom_range(0, 8191);
                default: off_v = $urandom_range(0, base_n);
            endcase
            case ($urandom_range(0, 7))
                0: len_v = 0;
                1: len_v = 8191;
                2: len_v = $urandom_range(0, 8191);
                default: len_v = $urandom_range(0, base_n);
            endcase
            reg_write(afe_pkg::REG_FADE_MODE, {31'($urandom()), md});
            reg_write(afe_pkg::REG_BUFFER_SIZE, 32'(sz) | (($urandom_range(0, 1) == 1) ?
                      ($urandom() << CFG_W) : 32'd0));
            reg_write(afe_pkg::REG_FADE_OFFSET, 32'(off_v) | (($urandom_range(0, 1) == 1) ?
                      ($urandom() << CFG_W) : 32'd0));
            reg_write(afe_pkg::REG_RAMP_LEN, 32'(len_v) | (($urandom_range(0, 1) == 1) ?
                      ($urandom() << CFG_W) : 32'd0));

            // two phases run with no idling, and the second of them also stalls the result side for a while
            calm = (ph == 3) || (ph == 5);
            if (ph == 5)
                hold_req = 1'b1;
            nsmp = (ph == 5) ? 60 : $urandom_range(8, 90);
            repeat (nsmp) begin
                case ($urandom_range(0, 9))
                    0: smp = 16'sh7FFF;
                    1: smp = 16'sh8000;
                    2: smp = SW'($urandom_range(0, 16)) - SW'(8);
                    default: smp = SW'($urandom());
                endcase
                offer_sample(smp);
                faded_q.push_back(fade_sample(smp));
            end
            ph++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("ran %0d samples over %0d settings, %0d register writes in all",
                 sent, ph, cfg_writes);
        $display("compared %0d results, %0d of them closing a block", checked, ends_seen);
        if (errors == 0)
            $display("audio_fade_envelope_unit: match");
        else
            $display("audio_fade_envelope_unit: mismatch");
        $finish;
    end
endmodule

[filelist.f]
src/afe_pkg.sv
src/afe_front.sv
src/afe_queue.sv
src/afe_back.sv
src/audio_fade_envelope_unit.sv
bench/testbench.sv
